// ===== rtl/qrm_pkg.sv =====
// Shared constants for the quaternion to rotation matrix block.
// No dependencies; used by qrm_div and the top level.
package qrm_pkg;

   // Default payload format: signed Q2.14 in 16 bits
   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   // Snap threshold register
   localparam int                THR_W     = 14;
   localparam logic [THR_W-1:0]  THR_RESET = 14'd16;

   // Widest sum of squares kept; larger sums saturate to all ones
   localparam int SUM_MAX_W = 64;

   // Quaternion components per item, matrix entries per item
   localparam int NUM_COMP  = 4;
   localparam int NUM_ENTRY = 9;

endpackage

// ===== rtl/qrm_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Uses no package items; instantiated by the top level.
module qrm_sqrt #(
   parameter int SUM_W  = 33,
   parameter int ROOT_W = 17,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [SUM_W-1:0]  in_sum,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int W2 = 2 * ROOT_W + 1;

   logic [SUM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];
   logic              vld_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int I = ROOT_W - 1 - k;
      logic [SUM_W-1:0]  rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [SIDE_W-1:0] side_p;
      logic              vld_p;
      logic [W2-1:0]     inc;

      if (k == 0) begin : g_first
         assign rem_p  = in_sum;
         assign root_p = '0;
         assign side_p = in_side;
         assign vld_p  = in_vld;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign side_p = side_ff[k-1];
         assign vld_p  = vld_ff[k-1];
      end

      // (root + 2^I)^2 - root^2; root has no bits at or below I yet
      assign inc = (W2'(root_p) << (I + 1)) | (W2'(1) << (2 * I));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
      end

      // Try this root bit against the running remainder
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_p;
            if (W2'(rem_p) >= inc) begin
               rem_ff[k]  <= rem_p - SUM_W'(inc);
               root_ff[k] <= root_p | (ROOT_W'(1) << I);
            end else begin
               rem_ff[k]  <= rem_p;
               root_ff[k] <= root_p;
            end
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];

endmodule

// ===== rtl/qrm_div.sv =====
// Pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage.
// Depends on qrm_pkg for the lane count; instantiated by the top level.
module qrm_div #(
   parameter int DVD_W  = 31,
   parameter int DIV_W  = 17,
   parameter int Q_W    = 15,
   parameter int SIDE_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [DVD_W-1:0]  in_dvd  [qrm_pkg::NUM_COMP],
   input  logic [DIV_W-1:0]  in_div,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [Q_W-1:0]    out_quot [qrm_pkg::NUM_COMP],
   output logic [SIDE_W-1:0] out_side
);

   localparam int NL = qrm_pkg::NUM_COMP;
   localparam int CW = (DVD_W > DIV_W + Q_W) ? DVD_W : DIV_W + Q_W;

   logic [DVD_W-1:0]  rem_ff  [Q_W][NL];
   logic [Q_W-1:0]    quot_ff [Q_W][NL];
   logic [DIV_W-1:0]  div_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];
   logic              vld_ff  [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int J = Q_W - 1 - k;
      logic [DVD_W-1:0]  rem_p  [NL];
      logic [Q_W-1:0]    quot_p [NL];
      logic [DIV_W-1:0]  div_p;
      logic [SIDE_W-1:0] side_p;
      logic              vld_p;
      logic [CW-1:0]     trial;

      if (k == 0) begin : g_first
         for (genvar l = 0; l < NL; l++) begin : g_lane
            assign rem_p[l]  = in_dvd[l];
            assign quot_p[l] = '0;
         end
         assign div_p  = in_div;
         assign side_p = in_side;
         assign vld_p  = in_vld;
      end else begin : g_next
         for (genvar l = 0; l < NL; l++) begin : g_lane
            assign rem_p[l]  = rem_ff[k-1][l];
            assign quot_p[l] = quot_ff[k-1][l];
         end
         assign div_p  = div_ff[k-1];
         assign side_p = side_ff[k-1];
         assign vld_p  = vld_ff[k-1];
      end

      assign trial = CW'(div_p) << J;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
      end

      // Subtract the shifted divisor where it fits
      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[k]  <= div_p;
            side_ff[k] <= side_p;
            for (int l = 0; l < NL; l++) begin
               if (CW'(rem_p[l]) >= trial) begin
                  rem_ff[k][l]  <= rem_p[l] - DVD_W'(trial);
                  quot_ff[k][l] <= quot_p[l] | (Q_W'(1) << J);
               end else begin
                  rem_ff[k][l]  <= rem_p[l];
                  quot_ff[k][l] <= quot_p[l];
               end
            end
         end
      end
   end

   assign out_vld  = vld_ff[Q_W-1];
   assign out_side = side_ff[Q_W-1];
   for (genvar l = 0; l < NL; l++) begin : g_out
      assign out_quot[l] = quot_ff[Q_W-1][l];
   end

endmodule

// ===== rtl/quaternion_to_rotation_matrix_top.sv =====
// Quaternion (w,x,y,z) to row-major 3x3 rotation matrix, fixed point. The quaternion is
// normalized by the integer square root of its sum of squares, small components and
// matrix entries near 0, +1 and -1 are snapped using the csr threshold, and entries
// saturate to DATA_WIDTH. One item is accepted every cycle unless the output register holds
// a result that rsp_tready does not take, which stalls the whole pipeline. Depends on
// qrm_pkg, qrm_sqrt and qrm_div.
module quaternion_to_rotation_matrix_top #(
   parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = qrm_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Threshold register write
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [qrm_pkg::THR_W-1:0]                csr_data,
   // Input items; tdata: q_w, q_x, q_y, q_z
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]        req_tdata,
   // Result items; tdata: r00 r01 r02 r10 r11 r12 r20 r21 r22; tuser: degenerate
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((9*DATA_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   output logic                                     rsp_tuser
);

   localparam int DW         = DATA_WIDTH;
   localparam int F          = FRAC_BITS;
   localparam int NC         = qrm_pkg::NUM_COMP;
   localparam int NE         = qrm_pkg::NUM_ENTRY;
   localparam int T_W        = qrm_pkg::THR_W;
   localparam int SUM_FULL_W = 2 * DW + 1;
   localparam int SUM_W      = (SUM_FULL_W > qrm_pkg::SUM_MAX_W) ? qrm_pkg::SUM_MAX_W
                                                                 : SUM_FULL_W;
   localparam int ROOT_W     = (SUM_W + 1) / 2;
   localparam int Q_W        = F + 1;
   localparam int DVD_W      = ((DW + F > ROOT_W - 1) ? DW + F : ROOT_W - 1) + 1;
   localparam int CMP_W      = ((ROOT_W > Q_W) ? ROOT_W : Q_W) + T_W + 1;
   localparam int U_W        = F + 2;
   localparam int P_W        = 2 * U_W;
   localparam int E_W        = 2 * F + 5;
   localparam int R_W        = E_W - F + 1;
   localparam int S_W        = ((R_W > DW) ? R_W : DW) + 2;
   localparam int SQ_SIDE_W  = NC + NC * DW;
   localparam int DV_SIDE_W  = NC + 1;

   // Threshold register
   logic [T_W-1:0] thr_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= qrm_pkg::THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // Whole pipeline advances when the output register is empty or being read
   logic adv;
   logic rsp_vld_ff;
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_vld_ff;

   // Stage 1: input capture
   logic                 v1_ff;
   logic signed [DW-1:0] q1_ff [NC];
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NC; i++) begin
            q1_ff[i] <= $signed(req_tdata[i*DW +: DW]);
         end
      end
   end

   // Stage 2: magnitudes and squares
   logic [DW-1:0]   mag1 [NC];
   logic            v2_ff;
   logic [2*DW-1:0] sq2_ff  [NC];
   logic [DW-1:0]   mag2_ff [NC];
   logic [NC-1:0]   sgn2_ff;
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         mag1[i] = q1_ff[i][DW-1] ? DW'(-q1_ff[i]) : DW'(q1_ff[i]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NC; i++) begin
            sq2_ff[i]  <= (2*DW)'(mag1[i]) * (2*DW)'(mag1[i]);
            mag2_ff[i] <= mag1[i];
            sgn2_ff[i] <= q1_ff[i][DW-1];
         end
      end
   end

   // Stage 3: sum of squares, saturated to the kept width
   logic [SUM_FULL_W-1:0] sum_full;
   logic                  v3_ff;
   logic [SUM_W-1:0]      sum3_ff;
   logic [DW-1:0]         mag3_ff [NC];
   logic [NC-1:0]         sgn3_ff;
   assign sum_full = SUM_FULL_W'(sq2_ff[0]) + SUM_FULL_W'(sq2_ff[1])
                   + SUM_FULL_W'(sq2_ff[2]) + SUM_FULL_W'(sq2_ff[3]);
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sum3_ff <= ((sum_full >> SUM_W) != '0) ? '1 : SUM_W'(sum_full);
         mag3_ff <= mag2_ff;
         sgn3_ff <= sgn2_ff;
      end
   end

   // Norm: square root of the sum
   logic [SQ_SIDE_W-1:0] sq_side_in, sq_side_out;
   logic                 vs_out;
   logic [ROOT_W-1:0]    root;
   always_comb begin
      sq_side_in = '0;
      sq_side_in[NC-1:0] = sgn3_ff;
      for (int i = 0; i < NC; i++) begin
         sq_side_in[NC + i*DW +: DW] = mag3_ff[i];
      end
   end

   qrm_sqrt #(
      .SUM_W  (SUM_W),
      .ROOT_W (ROOT_W),
      .SIDE_W (SQ_SIDE_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (v3_ff),
      .in_sum   (sum3_ff),
      .in_side  (sq_side_in),
      .out_vld  (vs_out),
      .out_root (root),
      .out_side (sq_side_out)
   );

   // Degenerate test and rounded dividends
   logic                 degen_s;
   logic [DVD_W-1:0]     dvd [NC];
   logic [DV_SIDE_W-1:0] dv_side_in, dv_side_out;
   logic                 vd_out;
   logic [Q_W-1:0]       quot [NC];
   assign degen_s = (root == '0) || (CMP_W'(root) < CMP_W'(thr_ff));
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         dvd[i] = (DVD_W'(sq_side_out[NC + i*DW +: DW]) << F) + DVD_W'(root >> 1);
      end
   end
   assign dv_side_in = {degen_s, sq_side_out[NC-1:0]};

   qrm_div #(
      .DVD_W  (DVD_W),
      .DIV_W  (ROOT_W),
      .Q_W    (Q_W),
      .SIDE_W (DV_SIDE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (vs_out),
      .in_dvd   (dvd),
      .in_div   (root),
      .in_side  (dv_side_in),
      .out_vld  (vd_out),
      .out_quot (quot),
      .out_side (dv_side_out)
   );

   // Unit quaternion: component snap, sign, identity on degenerate norm
   logic                  vu_ff;
   logic                  degu_ff;
   logic signed [U_W-1:0] u_ff [NC];
   always_ff @(posedge clock) begin
      if (reset) begin
         vu_ff <= 1'b0;
      end else if (adv) begin
         vu_ff <= vd_out;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         degu_ff <= dv_side_out[NC];
         for (int i = 0; i < NC; i++) begin
            if (dv_side_out[NC]) begin
               u_ff[i] <= (i == 0) ? (U_W'(1) << F) : '0;
            end else if (CMP_W'(quot[i]) < CMP_W'(thr_ff)) begin
               u_ff[i] <= '0;
            end else if (dv_side_out[i]) begin
               u_ff[i] <= -$signed(U_W'(quot[i]));
            end else begin
               u_ff[i] <= $signed(U_W'(quot[i]));
            end
         end
      end
   end

   // Products: wx wy wz xx xy xz yy yz zz
   logic                  vp_ff;
   logic                  degp_ff;
   logic signed [P_W-1:0] wx_ff, wy_ff, wz_ff, xx_ff, xy_ff, xz_ff, yy_ff, yz_ff, zz_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (adv) begin
         vp_ff <= vu_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         degp_ff <= degu_ff;
         wx_ff   <= P_W'(u_ff[0]) * P_W'(u_ff[1]);
         wy_ff   <= P_W'(u_ff[0]) * P_W'(u_ff[2]);
         wz_ff   <= P_W'(u_ff[0]) * P_W'(u_ff[3]);
         xx_ff   <= P_W'(u_ff[1]) * P_W'(u_ff[1]);
         xy_ff   <= P_W'(u_ff[1]) * P_W'(u_ff[2]);
         xz_ff   <= P_W'(u_ff[1]) * P_W'(u_ff[3]);
         yy_ff   <= P_W'(u_ff[2]) * P_W'(u_ff[2]);
         yz_ff   <= P_W'(u_ff[2]) * P_W'(u_ff[3]);
         zz_ff   <= P_W'(u_ff[3]) * P_W'(u_ff[3]);
      end
   end

   // Matrix entries at 2*F fraction bits
   logic signed [E_W-1:0] one2;
   logic signed [E_W-1:0] e_in [NE];
   logic                  ve_ff;
   logic                  dege_ff;
   logic signed [E_W-1:0] e_ff [NE];
   assign one2 = E_W'(1) << (2 * F);
   always_comb begin
      e_in[0] = one2 - ((E_W'(yy_ff) + E_W'(zz_ff)) <<< 1);
      e_in[1] = (E_W'(xy_ff) - E_W'(wz_ff)) <<< 1;
      e_in[2] = (E_W'(xz_ff) + E_W'(wy_ff)) <<< 1;
      e_in[3] = (E_W'(xy_ff) + E_W'(wz_ff)) <<< 1;
      e_in[4] = one2 - ((E_W'(xx_ff) + E_W'(zz_ff)) <<< 1);
      e_in[5] = (E_W'(yz_ff) - E_W'(wx_ff)) <<< 1;
      e_in[6] = (E_W'(xz_ff) - E_W'(wy_ff)) <<< 1;
      e_in[7] = (E_W'(yz_ff) + E_W'(wx_ff)) <<< 1;
      e_in[8] = one2 - ((E_W'(xx_ff) + E_W'(yy_ff)) <<< 1);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (adv) begin
         ve_ff <= vp_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         dege_ff <= degp_ff;
         e_ff    <= e_in;
      end
   end

   // Round to F fraction bits, half away from zero
   logic [E_W-1:0]        e_mag [NE];
   logic [E_W-1:0]        e_rnd [NE];
   logic                  vr_ff;
   logic                  degr_ff;
   logic signed [R_W-1:0] r_ff [NE];
   always_comb begin
      for (int k = 0; k < NE; k++) begin
         e_mag[k] = e_ff[k][E_W-1] ? E_W'(-e_ff[k]) : E_W'(e_ff[k]);
         e_rnd[k] = (e_mag[k] + (E_W'(1) << (F - 1))) >> F;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (adv) begin
         vr_ff <= ve_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         degr_ff <= dege_ff;
         for (int k = 0; k < NE; k++) begin
            r_ff[k] <= e_ff[k][E_W-1] ? -$signed(R_W'(e_rnd[k])) : $signed(R_W'(e_rnd[k]));
         end
      end
   end

   // Snap to 0, +1, -1 in that order, then saturate
   logic signed [S_W-1:0] one_s, eps_s, hi_s, lo_s;
   logic signed [S_W-1:0] rs [NE];
   logic signed [S_W-1:0] d1 [NE];
   logic signed [S_W-1:0] d2 [NE];
   logic signed [S_W-1:0] a0 [NE];
   logic signed [S_W-1:0] a1 [NE];
   logic signed [S_W-1:0] a2 [NE];
   logic signed [S_W-1:0] sn [NE];
   logic signed [S_W-1:0] st [NE];
   assign one_s = S_W'(1) << F;
   assign eps_s = $signed(S_W'(thr_ff));
   assign hi_s  = (S_W'(1) << (DW - 1)) - S_W'(1);
   assign lo_s  = -(S_W'(1) << (DW - 1));
   always_comb begin
      for (int k = 0; k < NE; k++) begin
         rs[k] = S_W'(r_ff[k]);
         d1[k] = rs[k] - one_s;
         d2[k] = rs[k] + one_s;
         a0[k] = (rs[k] < 0) ? -rs[k] : rs[k];
         a1[k] = (d1[k] < 0) ? -d1[k] : d1[k];
         a2[k] = (d2[k] < 0) ? -d2[k] : d2[k];
         priority if (a0[k] < eps_s) begin
            sn[k] = '0;
         end else if (a1[k] < eps_s) begin
            sn[k] = one_s;
         end else if (a2[k] < eps_s) begin
            sn[k] = -one_s;
         end else begin
            sn[k] = rs[k];
         end
         priority if (sn[k] > hi_s) begin
            st[k] = hi_s;
         end else if (sn[k] < lo_s) begin
            st[k] = lo_s;
         end else begin
            st[k] = sn[k];
         end
      end
   end

   // Output register
   logic [DW-1:0] rsp_data_ff [NE];
   logic          rsp_deg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= vr_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_deg_ff <= degr_ff;
         for (int k = 0; k < NE; k++) begin
            rsp_data_ff[k] <= DW'(st[k]);
         end
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < NE; k++) begin
         rsp_tdata[k*DW +: DW] = rsp_data_ff[k];
      end
   end
   assign rsp_tuser = rsp_deg_ff;

endmodule
